/* rtl/csal_pkg.sv */
package csal_pkg;

	localparam int unsigned NUM_STEPS = 5;
	localparam logic [2:0] MAX_STEP = 3'd4;
	localparam int unsigned DIV_W = 28;
	localparam logic [17:0] LUX_MAX = 18'h3FFFF;
	localparam logic [27:0] CT_SAT = 28'hFFFFFFF;
	localparam logic [34:0] K_RED = 35'd8913;
	localparam logic [34:0] K_BLUE = 35'd29098;
	localparam logic [42:0] K_LUX = 43'd310;
	localparam logic [27:0] K_CT = 28'd3810;
	localparam logic [27:0] CT_OFFSET = 28'd1391;
	localparam logic [7:0] ATIME_LONG = 8'h00;
	localparam logic [7:0] ATIME_SHORT = 8'hC0;

	typedef struct packed {
		logic [15:0] red_count;
		logic [15:0] green_count;
		logic [15:0] blue_count;
		logic [15:0] clear_count;
	} csal_in_t;

	typedef struct packed {
		logic [2:0]  range_index;
		logic [5:0]  gain_times;
		logic [7:0]  integration_code;
		logic        reading_used;
		logic        saturated;
		logic [15:0] ir_estimate;
		logic [15:0] red_comp;
		logic [15:0] green_comp;
		logic [15:0] blue_comp;
		logic [15:0] clear_comp;
		logic [17:0] lux_value;
		logic [27:0] color_temp;
	} csal_out_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [15:0]      divisor;
	} csal_div_req_t;

	function automatic logic [5:0] step_gain(input logic [2:0] s);
		unique case (s)
			3'd0, 3'd1: step_gain = 6'd60;
			3'd2:       step_gain = 6'd16;
			3'd3:       step_gain = 6'd4;
			default:    step_gain = 6'd1;
		endcase
	endfunction

	function automatic logic [7:0] step_code(input logic [2:0] s);
		step_code = (s == 3'd0) ? ATIME_LONG : ATIME_SHORT;
	endfunction

	function automatic logic [15:0] step_max(input logic [2:0] s);
		unique case (s)
			3'd0:             step_max = 16'd20000;
			3'd1, 3'd2, 3'd3: step_max = 16'd63000;
			default:          step_max = 16'd0;
		endcase
	endfunction

	function automatic logic [15:0] step_min(input logic [2:0] s);
		unique case (s)
			3'd0:    step_min = 16'd0;
			3'd1:    step_min = 16'd4990;
			3'd2:    step_min = 16'd16790;
			default: step_min = 16'd15740;
		endcase
	endfunction

	// integration milliseconds times gain
	function automatic logic [15:0] step_den(input logic [2:0] s);
		unique case (s)
			3'd0:    step_den = 16'd36840;
			3'd1:    step_den = 16'd9180;
			3'd2:    step_den = 16'd2448;
			3'd3:    step_den = 16'd612;
			default: step_den = 16'd153;
		endcase
	endfunction

endpackage

/* rtl/csal_in_if.sv */
interface csal_in_if import csal_pkg::*; ();
	logic     valid;
	logic     ready;
	csal_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/csal_out_if.sv */
interface csal_out_if import csal_pkg::*; ();
	logic      valid;
	logic      ready;
	csal_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/csal_div.sv */
module csal_div import csal_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  csal_div_req_t    req,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	logic [DIV_W-1:0] dq_q;
	logic [15:0]      rem_q;
	logic [15:0]      div_q;
	logic [4:0]       cnt_q;
	logic             done_q;
	logic [16:0]      rem_sh;
	logic             ge;
	logic [16:0]      rem_nx;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign ge = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? rem_sh - {1'b0, div_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= 5'(DIV_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 5'd1);
			if (cnt_q != '0) cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			dq_q <= {dq_q[DIV_W-2:0], ge};
			rem_q <= rem_nx[15:0];
		end
	end

	assign done = done_q;
	assign quotient = dq_q;
endmodule

/* rtl/color_sensor_autorange_lux_core.sv */
// Color sensor auto-range, lux and color temperature core.
// in_ch carries one raw red, green, blue and clear reading per item; out_ch returns
// one result item for each input item, in order.
// A reading that moves the range step (hysteresis on the clear count) yields a
// result with reading_used low and zero values, registered in the output register.
// The reading after a step is used without a range check.
// A used reading goes through compensation and constant multiplies, then two
// passes of one shared bit-serial restoring divider (lux, then color temperature),
// each a start, a load and a bit step for each of the 28 quotient bits.
// With red_comp zero the second pass is skipped.
// in_ch is ready only while no item is being worked on, so a new item is not accepted
// until the last one has reached the output register.
// The result sits in an output register: a new item is accepted while it waits,
// and a stalled receiver only holds the finished result and the next one back.
// Reset clears the range step to 0 (dimmest), the re-read flag and out_ch valid.
module color_sensor_autorange_lux_core import csal_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	csal_in_if.sink    in_ch,
	csal_out_if.source out_ch
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_COMP, ST_MUL1, ST_MUL2, ST_LUX, ST_LUXDIV, ST_CTDIV, ST_DONE
	} state_t;

	state_t        state_q;
	logic [2:0]    step_q;
	logic          sw_q;
	logic          used_q;
	csal_in_t      in_q;
	logic [15:0]   ir_q, rc_q, gc_q, bc_q, cc_q;
	logic [34:0]   acc_q;
	logic [17:0]   lux_q;
	logic [27:0]   ct_q;
	csal_div_req_t div_req;
	logic          div_start_q;
	logic [DIV_W-1:0] div_dvd_q;
	logic [15:0]   div_dvs_q;
	logic          div_done;
	logic [DIV_W-1:0] div_quo;
	csal_out_t     out_q;
	logic          out_valid_q;

	logic          take;
	logic          go_up, go_dn;
	logic [17:0]   sum;
	logic [16:0]   exc;
	logic [15:0]   ir;
	logic [42:0]   lux_t;

	assign take = in_ch.valid && (state_q == ST_IDLE);
	assign go_up = !sw_q && step_max(step_q) != 16'd0 && in_ch.data.clear_count > step_max(step_q);
	assign go_dn = !sw_q && !go_up && step_min(step_q) != 16'd0
		&& in_ch.data.clear_count < step_min(step_q);
	assign sum = 18'(in_q.red_count) + 18'(in_q.green_count) + 18'(in_q.blue_count);
	assign exc = 17'((sum - 18'(in_q.clear_count)) >> 1);
	assign ir = (sum > 18'(in_q.clear_count)) ? exc[15:0] : 16'd0;
	assign lux_t = 43'(acc_q[33:0]) * K_LUX;
	assign div_req = '{start: div_start_q, dividend: div_dvd_q, divisor: div_dvs_q};

	csal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			sw_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_LUX)
				|| (state_q == ST_LUXDIV && div_done && rc_q != 16'd0);
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (go_up) begin
							step_q <= step_q + 3'd1;
							sw_q <= 1'b1;
							state_q <= ST_DONE;
						end else if (go_dn) begin
							step_q <= step_q - 3'd1;
							sw_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							sw_q <= 1'b0;
							state_q <= ST_COMP;
						end
					end
				end
				ST_COMP: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_LUX;
				ST_LUX: state_q <= ST_LUXDIV;
				ST_LUXDIV: begin
					if (div_done) begin
						if (rc_q != 16'd0) begin
							state_q <= ST_CTDIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CTDIV: if (div_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			in_q <= in_ch.data;
			used_q <= !(go_up || go_dn);
		end
		if (state_q == ST_COMP) begin
			ir_q <= ir;
			rc_q <= in_q.red_count - ir;
			gc_q <= in_q.green_count - ir;
			bc_q <= in_q.blue_count - ir;
			cc_q <= in_q.clear_count - ir;
		end
		if (state_q == ST_MUL1) acc_q <= {3'b0, gc_q, 16'h0} + 35'(rc_q) * K_RED;
		if (state_q == ST_MUL2) acc_q <= acc_q - 35'(bc_q) * K_BLUE;
		if (state_q == ST_LUX) begin
			div_dvd_q <= (acc_q[34] || acc_q == '0) ? '0 : DIV_W'(lux_t[42:16]);
			div_dvs_q <= step_den(step_q);
		end
		if (state_q == ST_LUXDIV && div_done) begin
			lux_q <= (div_quo > DIV_W'(LUX_MAX)) ? LUX_MAX : div_quo[17:0];
			div_dvd_q <= DIV_W'(28'(bc_q) * K_CT);
			div_dvs_q <= rc_q;
			ct_q <= CT_SAT;
		end
		if (state_q == ST_CTDIV && div_done) ct_q <= div_quo + CT_OFFSET;
		if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_q.range_index <= step_q;
			out_q.gain_times <= step_gain(step_q);
			out_q.integration_code <= step_code(step_q);
			out_q.reading_used <= used_q;
			out_q.saturated <= 1'b0;
			out_q.ir_estimate <= used_q ? ir_q : '0;
			out_q.red_comp <= used_q ? rc_q : '0;
			out_q.green_comp <= used_q ? gc_q : '0;
			out_q.blue_comp <= used_q ? bc_q : '0;
			out_q.clear_comp <= used_q ? cc_q : '0;
			out_q.lux_value <= used_q ? lux_q : '0;
			out_q.color_temp <= used_q ? ct_q : '0;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
endmodule
